FILE: src/rarsb_pkg.sv
// Package for the range-add / range-sum block array.
// Holds the transaction structs, action codes and default sizes.
// Used by the top level; no dependencies.
package rarsb_pkg;

	localparam int MAX_ELEMENTS_DEF = 256;
	localparam int BLOCK_SIZE_DEF   = 16;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_ADD  = 2'd1;
	localparam logic [1:0] ACT_SUM  = 2'd2;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	typedef struct packed {
		logic [1:0]         action;
		logic [7:0]         index_low;
		logic [7:0]         index_high;
		logic signed [31:0] value;
	} item_t;

	typedef struct packed {
		logic signed [63:0] range_sum;
		logic               status;
	} result_t;

	// One block entry: sum of stored element parts and the pending add
	typedef struct packed {
		logic [63:0] sum;
		logic [63:0] pend;
	} blk_entry_t;

endpackage

FILE: src/rarsb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read during a write to the same address returns the old contents.
// No dependencies.
module rarsb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/range_add_range_sum_blocks.sv
// Range add / range sum over a block-split element array, one RAM read-modify-write per step.
// A query walks S steps (one per edge element, one per whole block, at most 44 for 16-element
// blocks over 256 elements); a bad range reports its status without a walk. A new transaction
// is taken only once the current one is done, and a query waits while its result is stalled.
// Reset: the RAMs clear over all MAX_ELEMENTS addresses first; the length returns to 256.
module range_add_range_sum_blocks
	import rarsb_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int BLOCK_SIZE   = BLOCK_SIZE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_stall,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [8:0] cfg_data
);

	localparam int NUM_BLOCKS = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam int EA_W       = $clog2(MAX_ELEMENTS);
	localparam int BA_W       = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int OFF_W      = $clog2(BLOCK_SIZE);
	localparam int POS_W      = 10;
	localparam int LEN_W      = ($clog2(MAX_ELEMENTS + 1) > 10) ? $clog2(MAX_ELEMENTS + 1) : 10;
	// Index / BLOCK_SIZE as a multiply by a reciprocal, exact for 8-bit indexes
	localparam int RECIP_SH   = 8 + $clog2(BLOCK_SIZE);
	localparam int RECIP_W    = RECIP_SH + 1;
	localparam int PROD_W     = 8 + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'((2 ** RECIP_SH) / BLOCK_SIZE + 1);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_PREP  = 7'b0000100,
		ST_PREP2 = 7'b0001000,
		ST_RUN   = 7'b0010000,
		ST_DRAIN = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {
		STEP_PART  = 2'd0,
		STEP_WHOLE = 2'd1,
		STEP_LOAD  = 2'd2
	} step_t;

	state_t            state_q;
	logic [8:0]        length_q;
	logic [EA_W-1:0]   clr_q;

	logic [1:0]        op_q;
	logic [7:0]        lo_q;
	logic [7:0]        hi_q;
	logic [63:0]       amt_q;
	logic              bad_q;
	logic [63:0]       acc_q;

	logic [POS_W-1:0]  i_q;
	logic [BA_W-1:0]   blk_q;
	logic [OFF_W-1:0]  off_q;

	logic              valid_s1;
	step_t             kind_s1;
	logic [EA_W-1:0]   eaddr_s1;
	logic [BA_W-1:0]   baddr_s1;
	logic              fwd_s1;
	blk_entry_t        blk_wr_q;

	logic              res_valid_q;
	result_t           res_q;

	// RAM ports
	logic              elem_we;
	logic [EA_W-1:0]   elem_waddr;
	logic [63:0]       elem_wdata;
	logic [EA_W-1:0]   elem_raddr;
	logic [63:0]       elem_rdata;
	logic              blk_we;
	logic [BA_W-1:0]   blk_waddr;
	blk_entry_t        blk_wdata;
	logic [BA_W-1:0]   blk_raddr;
	blk_entry_t        blk_rdata;

	// Setup and walk signals
	logic [LEN_W-1:0]  lim_ext;
	logic              bad_d;
	logic [PROD_W-1:0] quot_prod;
	logic              whole;
	logic [POS_W-1:0]  next_i;
	logic              last;
	logic              issue;

	// Stage 1 signals
	blk_entry_t        blk_cur;
	logic [63:0]       fresh;
	logic [63:0]       acc_d;
	logic              res_load;

	rarsb_ram #(
		.WIDTH (64),
		.DEPTH (MAX_ELEMENTS)
	) u_elem_ram (
		.clk   (clk),
		.we    (elem_we),
		.waddr (elem_waddr),
		.wdata (elem_wdata),
		.raddr (elem_raddr),
		.rdata (elem_rdata)
	);

	rarsb_ram #(
		.WIDTH ($bits(blk_entry_t)),
		.DEPTH (NUM_BLOCKS)
	) u_blk_ram (
		.clk   (clk),
		.we    (blk_we),
		.waddr (blk_waddr),
		.wdata (blk_wdata),
		.raddr (blk_raddr),
		.rdata (blk_rdata)
	);

	assign item_stall   = (state_q != ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Range check against the saturated length
	assign lim_ext = (op_q == ACT_LOAD) ? LEN_W'(lo_q) : LEN_W'(hi_q);
	assign bad_d   = (lim_ext >= LEN_W'(length_q)) || (lim_ext >= LEN_W'(MAX_ELEMENTS)) ||
	                 ((op_q != ACT_LOAD) && (lo_q > hi_q));
	assign quot_prod = PROD_W'(lo_q) * PROD_W'(RECIP_M);

	// Walk: whole block when aligned and the block fits inside the range; a load takes one element step
	always_comb begin
		whole  = (op_q != ACT_LOAD) && (off_q == '0) &&
		         ((i_q + POS_W'(BLOCK_SIZE)) <= (POS_W'(hi_q) + POS_W'(1)));
		next_i = whole ? (i_q + POS_W'(BLOCK_SIZE)) : (i_q + POS_W'(1));
		last   = (op_q == ACT_LOAD) || (next_i > POS_W'(hi_q));
		issue  = (state_q == ST_RUN);
	end

	assign elem_raddr = EA_W'(i_q);
	assign blk_raddr  = blk_q;

	// Stage 1: read data is back; modify and write back (during the reset clear, zero both RAMs)
	always_comb begin
		blk_cur    = fwd_s1 ? blk_wr_q : blk_rdata;
		fresh      = amt_q - blk_cur.pend;
		acc_d      = acc_q;
		elem_we    = 1'b0;
		elem_waddr = eaddr_s1;
		elem_wdata = '0;
		blk_we     = 1'b0;
		blk_waddr  = baddr_s1;
		blk_wdata  = blk_cur;
		if (state_q == ST_CLEAR) begin
			elem_we    = 1'b1;
			elem_waddr = clr_q;
			blk_we     = (32'(clr_q) < 32'(NUM_BLOCKS));
			blk_waddr  = BA_W'(clr_q);
			blk_wdata  = '0;
		end else if (valid_s1) begin
			case (kind_s1)
				STEP_LOAD: begin
					elem_we        = 1'b1;
					elem_wdata     = fresh;
					blk_we         = 1'b1;
					blk_wdata.sum  = blk_cur.sum + fresh - elem_rdata;
				end
				STEP_PART: begin
					if (op_q == ACT_SUM) begin
						acc_d = acc_q + elem_rdata + blk_cur.pend;
					end else begin
						elem_we       = 1'b1;
						elem_wdata    = elem_rdata + amt_q;
						blk_we        = 1'b1;
						blk_wdata.sum = blk_cur.sum + amt_q;
					end
				end
				STEP_WHOLE: begin
					if (op_q == ACT_SUM) begin
						acc_d = acc_q + blk_cur.sum + blk_cur.pend * 64'(BLOCK_SIZE);
					end else begin
						blk_we         = 1'b1;
						blk_wdata.pend = blk_cur.pend + amt_q;
					end
				end
				default: begin
					acc_d = acc_q;
				end
			endcase
		end
	end

	assign res_load = (state_q == ST_DONE) && (!res_valid_q || !result_stall);

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			length_q    <= 9'd256;
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				length_q <= cfg_data;
			end
			valid_s1 <= issue;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + EA_W'(1);
					if (clr_q == EA_W'(MAX_ELEMENTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (op_q != ACT_LOAD && op_q != ACT_ADD && op_q != ACT_SUM) begin
						state_q <= ST_IDLE;
					end else if (bad_d) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_PREP2;
					end
				end
				ST_PREP2: begin
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= (op_q == ACT_SUM) ? ST_DONE : ST_IDLE;
				end
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			op_q  <= item.action;
			lo_q  <= item.index_low;
			hi_q  <= item.index_high;
			amt_q <= {{32{item.value[31]}}, item.value};
			acc_q <= '0;
		end else begin
			acc_q <= acc_d;
		end
		if (state_q == ST_PREP) begin
			bad_q <= bad_d;
			blk_q <= BA_W'(quot_prod >> RECIP_SH);
		end
		if (state_q == ST_PREP2) begin
			i_q   <= POS_W'(lo_q);
			off_q <= OFF_W'(POS_W'(lo_q) - POS_W'(32'(blk_q) * BLOCK_SIZE));
		end
		if (issue) begin
			// Advance position, offset and block
			i_q <= next_i;
			if (whole) begin
				blk_q <= blk_q + BA_W'(1);
			end else if (off_q == OFF_W'(BLOCK_SIZE - 1)) begin
				off_q <= '0;
				blk_q <= blk_q + BA_W'(1);
			end else begin
				off_q <= off_q + OFF_W'(1);
			end
			kind_s1  <= (op_q == ACT_LOAD) ? STEP_LOAD : (whole ? STEP_WHOLE : STEP_PART);
			eaddr_s1 <= EA_W'(i_q);
			baddr_s1 <= blk_q;
			// Forward the block entry being written when the same block is read now
			fwd_s1   <= valid_s1 && (op_q != ACT_SUM) && (baddr_s1 == blk_q);
		end
		if (blk_we) begin
			blk_wr_q <= blk_wdata;
		end
		if (res_load) begin
			res_q.range_sum <= bad_q ? 64'sd0 : acc_q;
			res_q.status    <= bad_q ? STATUS_BAD : STATUS_OK;
		end
	end

endmodule
